### hw/rtl/nns_pkg.sv
// Shared types, sizes and codes of the nearest-neighbor search block.
// Used by nns_ram users, the top level and its checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package nns_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int CFG_W      = 7;
	localparam int ENTRY_W    = 3 * COORD_BITS;
	localparam int SQ_W       = 2 * COORD_BITS;
	localparam int DIST_W     = SQ_W + 2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_NONE  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOADQ = 5'b00010,
		ST_CAPQ  = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	// Magnitude of the difference of two signed coordinates; it always fits
	// in COORD_BITS unsigned bits.
	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		logic signed [COORD_BITS:0] n;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		n = -d;
		return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/nns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module nns_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

### hw/rtl/nearest_neighbor_search.sv
// Top level of the nearest-neighbor search block: sequencer, distance unit, result register.
// Depends on nns_pkg and nns_ram.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_ready    opcode, entry_index, pos_x, pos_y, pos_z
// result    out_valid / out_ready  status, nearest_index, near_x, near_y, near_z
// config    cfg_valid / cfg_ready  cfg_data (point_count)
//
// After a write transfer the block stays ready.
// A query in range first reads the queried point (LOADQ, CAPQ), then sends each stored
// entry in turn through the single distance unit (one RAM read port, three squares,
// one add-compare) in SCAN, and drains the pipeline in DONE. An out-of-range query
// goes straight to DONE without reading the table.
// Reset is asynchronous and active low; the table itself is not cleared.
// A finished result waits in the output register; a new transfer is taken
// meanwhile, and a later query holds in its last state until the register is free.

module nearest_neighbor_search (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                opcode,
	input  wire logic [nns_pkg::IDX_W-1:0]           entry_index,
	input  wire logic signed [nns_pkg::COORD_BITS-1:0] pos_x,
	input  wire logic signed [nns_pkg::COORD_BITS-1:0] pos_y,
	input  wire logic signed [nns_pkg::COORD_BITS-1:0] pos_z,

	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [1:0]                               status,
	output logic [nns_pkg::IDX_W-1:0]                nearest_index,
	output logic signed [nns_pkg::COORD_BITS-1:0]    near_x,
	output logic signed [nns_pkg::COORD_BITS-1:0]    near_y,
	output logic signed [nns_pkg::COORD_BITS-1:0]    near_z,

	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [nns_pkg::CFG_W-1:0]           cfg_data
);

	localparam int CB = nns_pkg::COORD_BITS;

	nns_pkg::state_t state_q;

	logic [nns_pkg::CFG_W-1:0] point_count_q;
	logic [nns_pkg::CNT_W-1:0] cnt_eff;
	logic [nns_pkg::CNT_W-1:0] cnt_q;
	logic [nns_pkg::CNT_W-1:0] scan_q;
	logic [nns_pkg::IDX_W-1:0] qidx_q;
	logic                      oor_q;

	// Coordinates of the queried point.
	logic signed [CB-1:0] qx_q, qy_q, qz_q;

	// Table port.
	logic                         wr_en;
	logic [nns_pkg::IDX_W-1:0]    rd_addr;
	logic [nns_pkg::ENTRY_W-1:0]  rd_data;
	logic signed [CB-1:0]         rx, ry, rz;

	// Distance pipeline: issue, squares, then accumulate into the best registers.
	logic                         tk_s0, v_s0;
	logic [nns_pkg::IDX_W-1:0]    idx_s0;
	logic                         tk_s1, v_s1;
	logic [nns_pkg::IDX_W-1:0]    idx_s1;
	logic [nns_pkg::SQ_W-1:0]     sqx_s1, sqy_s1, sqz_s1;
	logic [nns_pkg::ENTRY_W-1:0]  ent_s1;
	logic [nns_pkg::DIST_W-1:0]   dist_sum;

	logic                         found_q;
	logic [nns_pkg::DIST_W-1:0]   best_dist_q;
	logic [nns_pkg::IDX_W-1:0]    best_idx_q;
	logic [nns_pkg::ENTRY_W-1:0]  best_ent_q;

	logic                         in_xfer, out_free, finish;

	assign in_ready  = (state_q == nns_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid || out_ready;
	// A query is done once the pipeline is empty and the result register is free.
	assign finish    = (state_q == nns_pkg::ST_DONE) && !tk_s0 && !tk_s1 && out_free;

	// Counts above the table size saturate.
	always_comb begin
		if (int'(point_count_q) > nns_pkg::MAX_POINTS) begin
			cnt_eff = nns_pkg::CNT_W'(nns_pkg::MAX_POINTS);
		end else begin
			cnt_eff = nns_pkg::CNT_W'(point_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			point_count_q <= cfg_data;
		end
	end

	// Writes go straight into the table; entry_index always addresses a real entry.
	assign wr_en   = in_xfer && (opcode == nns_pkg::OP_WRITE);
	assign rd_addr = (state_q == nns_pkg::ST_LOADQ) ? qidx_q
	                                                : scan_q[nns_pkg::IDX_W-1:0];

	nns_ram #(
		.WIDTH (nns_pkg::ENTRY_W),
		.DEPTH (nns_pkg::MAX_POINTS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (entry_index),
		.wr_data ({pos_z, pos_y, pos_x}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rx = rd_data[CB-1:0];
	assign ry = rd_data[2*CB-1:CB];
	assign rz = rd_data[3*CB-1:2*CB];

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nns_pkg::ST_IDLE;
			tk_s0   <= 1'b0;
			v_s0    <= 1'b0;
		end else begin
			tk_s0 <= 1'b0;
			v_s0  <= 1'b0;
			case (state_q)
				nns_pkg::ST_IDLE: begin
					if (in_xfer && (opcode == nns_pkg::OP_QUERY)) begin
						if (nns_pkg::CNT_W'(entry_index) >= cnt_eff) begin
							state_q <= nns_pkg::ST_DONE;
						end else begin
							state_q <= nns_pkg::ST_LOADQ;
						end
					end
				end
				nns_pkg::ST_LOADQ: begin
					state_q <= nns_pkg::ST_CAPQ;
				end
				nns_pkg::ST_CAPQ: begin
					state_q <= nns_pkg::ST_SCAN;
				end
				nns_pkg::ST_SCAN: begin
					tk_s0 <= 1'b1;
					v_s0  <= (scan_q[nns_pkg::IDX_W-1:0] != qidx_q);
					if (scan_q == cnt_q - nns_pkg::CNT_W'(1)) begin
						state_q <= nns_pkg::ST_DONE;
					end
				end
				nns_pkg::ST_DONE: begin
					if (finish) begin
						state_q <= nns_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= nns_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Query context and scan counter.
	always_ff @(posedge clk) begin
		if (in_xfer && (opcode == nns_pkg::OP_QUERY)) begin
			qidx_q <= entry_index;
			cnt_q  <= cnt_eff;
			oor_q  <= (nns_pkg::CNT_W'(entry_index) >= cnt_eff);
		end
		if (state_q == nns_pkg::ST_CAPQ) begin
			qx_q   <= rx;
			qy_q   <= ry;
			qz_q   <= rz;
			scan_q <= '0;
		end else if (state_q == nns_pkg::ST_SCAN) begin
			scan_q <= scan_q + nns_pkg::CNT_W'(1);
		end
		idx_s0 <= scan_q[nns_pkg::IDX_W-1:0];
	end

	// Squares of the coordinate differences, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tk_s1 <= 1'b0;
			v_s1  <= 1'b0;
		end else begin
			tk_s1 <= tk_s0;
			v_s1  <= v_s0;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s1 <= nns_pkg::SQ_W'(nns_pkg::abs_diff(rx, qx_q))
		        * nns_pkg::SQ_W'(nns_pkg::abs_diff(rx, qx_q));
		sqy_s1 <= nns_pkg::SQ_W'(nns_pkg::abs_diff(ry, qy_q))
		        * nns_pkg::SQ_W'(nns_pkg::abs_diff(ry, qy_q));
		sqz_s1 <= nns_pkg::SQ_W'(nns_pkg::abs_diff(rz, qz_q))
		        * nns_pkg::SQ_W'(nns_pkg::abs_diff(rz, qz_q));
		idx_s1 <= idx_s0;
		ent_s1 <= rd_data;
	end

	assign dist_sum = nns_pkg::DIST_W'(sqx_s1) + nns_pkg::DIST_W'(sqy_s1)
	                + nns_pkg::DIST_W'(sqz_s1);

	// Entries arrive in ascending order, so a strict compare keeps the lowest
	// index on a tie.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (in_xfer && (opcode == nns_pkg::OP_QUERY)) begin
			found_q <= 1'b0;
		end else if (v_s1) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && (!found_q || (dist_sum < best_dist_q))) begin
			best_dist_q <= dist_sum;
			best_idx_q  <= idx_s1;
			best_ent_q  <= ent_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (oor_q) begin
				status <= nns_pkg::STATUS_RANGE;
			end else if (!found_q) begin
				status <= nns_pkg::STATUS_NONE;
			end else begin
				status <= nns_pkg::STATUS_OK;
			end
			if (!oor_q && found_q) begin
				nearest_index <= best_idx_q;
				near_x        <= best_ent_q[CB-1:0];
				near_y        <= best_ent_q[2*CB-1:CB];
				near_z        <= best_ent_q[3*CB-1:2*CB];
			end else begin
				nearest_index <= '0;
				near_x        <= '0;
				near_y        <= '0;
				near_z        <= '0;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/nns_checker.sv
// Port-level checks for the nearest-neighbor search block, bound to its top level.
// Depends on nns_pkg and nearest_neighbor_search.
`timescale 1ns / 1ps
`default_nettype none

module nns_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic                            opcode,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [1:0]                      status,
	input wire logic [nns_pkg::IDX_W-1:0]       nearest_index,
	input wire logic [nns_pkg::COORD_BITS-1:0]  near_x,
	input wire logic [nns_pkg::COORD_BITS-1:0]  near_y,
	input wire logic [nns_pkg::COORD_BITS-1:0]  near_z
);

	// A held result keeps its status, index and x coordinate.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(nearest_index) && $stable(near_x))
		else $error("result changed while stalled");

	// Only the three defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == nns_pkg::STATUS_OK) || (status == nns_pkg::STATUS_NONE)
			|| (status == nns_pkg::STATUS_RANGE))
		else $error("undefined status code");

	// A result without a neighbor carries zero fields.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != nns_pkg::STATUS_OK) |-> (nearest_index == '0)
			&& (near_x == '0) && (near_y == '0) && (near_z == '0))
		else $error("nonzero fields without a neighbor");

	// The block is not ready right after a query transfer.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == nns_pkg::OP_QUERY) |=> !in_ready)
		else $error("ready right after a query transfer");

	// A write leaves the block ready.
	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == nns_pkg::OP_WRITE) |=> in_ready)
		else $error("not ready after a write transfer");

endmodule

bind nearest_neighbor_search nns_checker u_nns_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.opcode        (opcode),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.nearest_index (nearest_index),
	.near_x        (near_x),
	.near_y        (near_y),
	.near_z        (near_z)
);

`default_nettype wire
